@@ rtl/prk_pkg.sv @@
// types, constants and the restoring divide step for pixel_to_ray_key
// no dependencies; imported by the top level and its checker
package prk_pkg;

    localparam int COORD_W  = 16;
    localparam int WORD_W   = 32;
    localparam int KEY_W    = 64;
    localparam int DEPTH_W  = 20;
    localparam int AZIM_W   = 18;
    localparam int ELEV_W   = 14;
    localparam int FRAME_W  = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = 16'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 16'd480;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // quotient bits produced by the azimuth and elevation dividers; elevation runs
    // with its dividend scaled by 2^(QUOT_W-ELEV_W)
    localparam int QUOT_W          = AZIM_W;
    localparam int REM_W           = COORD_W;
    localparam int DIVIDEND_W      = QUOT_W + REM_W;
    localparam int ELEV_PAD        = QUOT_W - ELEV_W;
    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES      = QUOT_W / STEPS_PER_STAGE;
    // input register, divide stages, output register
    localparam int PIPE_LATENCY    = DIV_STAGES + 2;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] shq;   // dividend bits shifting out, quotient bits shifting in
    } div_state_t;

    typedef struct packed {
        logic               az_clamp;
        logic               el_clamp;
        logic [DEPTH_W-1:0] depth;
        logic [FRAME_W-1:0] frame;
    } side_t;

    function automatic div_state_t div_step(div_state_t s, logic [REM_W-1:0] span);
        logic [REM_W:0] trial;
        div_state_t     r;
        trial = {s.rem, s.shq[QUOT_W-1]};
        if (trial >= {1'b0, span})
        begin
            r.rem = REM_W'(trial - {1'b0, span});
            r.shq = {s.shq[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[REM_W-1:0];
            r.shq = {s.shq[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [REM_W-1:0] size_to_span(logic [COORD_W-1:0] size);
        logic [REM_W-1:0] span;
        if (size < COORD_W'(2))
        begin
            span = REM_W'(1);
        end
        else
        begin
            span = size - COORD_W'(1);
        end
        return span;
    endfunction

endpackage

@@ rtl/pixel_to_ray_key.sv @@
// pixel_to_ray_key top level: pixel coordinates scaled to azimuth and elevation codes
// by a pipelined restoring divider, packed with depth and frame into one key
// depends on prk_pkg
//
//  channel   handshake               payload
//  input     start (busy always low) pixel_col, pixel_row, frame_number, depth_value
//  result    done strobe, one cycle  ray_key
//  config    cfg_write               cfg_index, cfg_data
//
// one transaction enters per cycle; done and ray_key come from the output register,
// behind the input register and the divide stages
// the pipeline holds 18 divide steps, 3 per stage over 6 stages, between input and output registers
// rst_n clears valid bits and sets image size to 640 by 480
// the result side cannot stall, so the pipeline never holds
module pixel_to_ray_key
    import prk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   pixel_col,
    input  logic [COORD_W-1:0]   pixel_row,
    input  logic [WORD_W-1:0]    frame_number,
    input  logic [WORD_W-1:0]    depth_value,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    output logic                 done,
    output logic [KEY_W-1:0]     ray_key
);

    logic [REM_W-1:0] span_w_reg;
    logic [REM_W-1:0] span_h_reg;

    logic       valid_reg [0:DIV_STAGES];
    div_state_t az_reg    [0:DIV_STAGES];
    div_state_t el_reg    [0:DIV_STAGES];
    side_t      side_reg  [0:DIV_STAGES];

    div_state_t az_next [1:DIV_STAGES];
    div_state_t el_next [1:DIV_STAGES];

    logic [DIVIDEND_W-1:0] az_dividend;
    logic [DIVIDEND_W-1:0] el_dividend;
    logic [DIVIDEND_W-ELEV_PAD-1:0] el_product;
    side_t side_in;
    logic  accept;

    logic [AZIM_W-1:0] azim_code;
    logic [ELEV_W-1:0] elev_code;
    side_t             side_last;

    logic              done_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration, kept as divisor spans
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_w_reg <= size_to_span(WIDTH_RESET);
            span_h_reg <= size_to_span(HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  span_w_reg <= size_to_span(cfg_data);
                CFG_IMAGE_HEIGHT: span_h_reg <= size_to_span(cfg_data);
                default:          span_w_reg <= span_w_reg;
            endcase
        end
    end

    // dividends: coordinate times (2^n - 1) as shift and subtract
    assign az_dividend = {pixel_col, {QUOT_W{1'b0}}} - {{QUOT_W{1'b0}}, pixel_col};
    assign el_product  = {pixel_row, {ELEV_W{1'b0}}} - {{ELEV_W{1'b0}}, pixel_row};
    assign el_dividend = {el_product, {ELEV_PAD{1'b0}}};

    always_comb
    begin
        side_in.az_clamp = (pixel_col >= span_w_reg);
        side_in.el_clamp = (pixel_row >= span_h_reg);
        side_in.depth    = (depth_value > WORD_W'(DEPTH_MAX)) ? DEPTH_MAX
                                                              : depth_value[DEPTH_W-1:0];
        side_in.frame    = frame_number[FRAME_W-1:0];
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        az_reg[0]   <= '{rem: az_dividend[DIVIDEND_W-1:QUOT_W], shq: az_dividend[QUOT_W-1:0]};
        el_reg[0]   <= '{rem: el_dividend[DIVIDEND_W-1:QUOT_W], shq: el_dividend[QUOT_W-1:0]};
        side_reg[0] <= side_in;
    end

    // divide stages
    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_stage
        always_comb
        begin
            az_next[g] = az_reg[g-1];
            el_next[g] = el_reg[g-1];
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                az_next[g] = div_step(az_next[g], span_w_reg);
                el_next[g] = div_step(el_next[g], span_h_reg);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= valid_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            az_reg[g]   <= az_next[g];
            el_reg[g]   <= el_next[g];
            side_reg[g] <= side_reg[g-1];
        end
    end

    // clamp and pack
    assign side_last = side_reg[DIV_STAGES];
    assign azim_code = side_last.az_clamp ? '1 : az_reg[DIV_STAGES].shq;
    assign elev_code = side_last.el_clamp ? '1 : el_reg[DIV_STAGES].shq[QUOT_W-1:ELEV_PAD];
    assign key_next  = {side_last.depth, azim_code, elev_code, side_last.frame};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign done    = done_reg;
    assign ray_key = key_reg;

endmodule

@@ rtl/prk_checker.sv @@
// port-level checks for pixel_to_ray_key, attached by bind
// depends on prk_pkg
module prk_port_checks
    import prk_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [WORD_W-1:0]  frame_number,
    input logic [WORD_W-1:0]  depth_value,
    input logic               done,
    input logic [KEY_W-1:0]   ray_key
);

    // every accepted transaction yields a key after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
        else $error("accepted transaction produced no result");

    // no result without a matching transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without accepted transaction");

    a_frame_field: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (ray_key[FRAME_W-1:0] == $past(frame_number[FRAME_W-1:0], PIPE_LATENCY)))
        else $error("frame field mismatch");

    a_depth_field: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (ray_key[KEY_W-1:KEY_W-DEPTH_W] ==
                  (($past(depth_value, PIPE_LATENCY) > WORD_W'(DEPTH_MAX)) ? DEPTH_MAX
                   : $past(depth_value[DEPTH_W-1:0], PIPE_LATENCY))))
        else $error("depth field mismatch");

endmodule

bind pixel_to_ray_key prk_port_checks u_prk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .frame_number (frame_number),
    .depth_value  (depth_value),
    .done         (done),
    .ray_key      (ray_key)
);
